// ===== sv/lgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step package
// Grid size, command codes and the transaction types shared by the block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_SIZE = 64;
    localparam int ROW_W     = $clog2(GRID_SIZE);
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    localparam logic [63:0] COL_MASK =
        (GRID_SIZE >= 64) ? {64{1'b1}} : ((64'd1 << GRID_SIZE) - 64'd1);

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } lgs_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
    } lgs_request_t;

    typedef struct packed {
        logic [63:0] row_data;
        logic        world_empty;
    } lgs_response_t;

endpackage

// ===== sv/lgs_row_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step row cell
// One grid row held in a register that takes its neighbour's row on a shift.
// ----------------------------------------------------------------------------
module lgs_row_cell
    import lgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift_en,
    input  logic [63:0] row_in,
    output logic [63:0] row_out
);

    logic [63:0] row_reg;
    logic [63:0] row_next;

    always_comb
    begin
        row_next = shift_en ? (row_in & COL_MASK) : row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_out = row_reg;

endmodule

// ===== sv/lgs_rule_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step rule unit
// Applies the B3/S23 rule to one row from the rows above and below it.
// ----------------------------------------------------------------------------
module lgs_rule_unit
    import lgs_pkg::*;
(
    input  logic [63:0] above,
    input  logic [63:0] current,
    input  logic [63:0] below,
    output logic [63:0] next_row
);

    logic [63:0] nb [8];
    logic [3:0]  count;
    logic [63:0] result;

    always_comb
    begin
        nb[0] = above << 1;
        nb[1] = above;
        nb[2] = above >> 1;
        nb[3] = current << 1;
        nb[4] = current >> 1;
        nb[5] = below << 1;
        nb[6] = below;
        nb[7] = below >> 1;
        result = '0;
        count  = '0;
        for (int j = 0; j < 64; j++)
        begin
            count = 4'({3'b000, nb[0][j]} + {3'b000, nb[1][j]} + {3'b000, nb[2][j]}
                     + {3'b000, nb[3][j]} + {3'b000, nb[4][j]} + {3'b000, nb[5][j]}
                     + {3'b000, nb[6][j]} + {3'b000, nb[7][j]});
            result[j] = (count == 4'(BIRTH_COUNT))
                        || (current[j] && (count == 4'(SURVIVE_COUNT)));
        end
        next_row = result & COL_MASK;
    end

endmodule

// ===== sv/life_generation_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step top level
// Conway B3/S23 engine on a grid kept in a ring of row cells.
// ----------------------------------------------------------------------------
// A transaction is taken on request when start is high and busy is low.
// Every transaction then rotates the ring of GRID_SIZE row cells once, one
// row per cycle: the head row is written, captured for a read, or replaced
// by its next generation from the rule unit, and goes back in at the tail.
// The same pass ORs every row to find whether the grid is empty.
// busy is high while the pass runs. The response appears on response with
// done high for exactly one cycle, the cycle after the pass ends, and a new
// transaction may be started in that cycle.
// row_data is zero except for a read; world_empty reports the grid after
// the transaction. The receiver cannot stall, and needs no buffering.
// Reset clears every row to dead cells, returns to idle and drops done.
// ----------------------------------------------------------------------------
module life_generation_step_top
    import lgs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lgs_request_t  request,
    output logic          done,
    output lgs_response_t response
);

    lgs_state_t    state_reg, state_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    lgs_request_t  req_reg, req_next;
    logic [63:0]   above_reg, above_next;
    logic [63:0]   data_reg, data_next;
    logic          live_reg, live_next;
    logic          done_reg, done_next;
    lgs_response_t resp_reg, resp_next;

    logic [63:0] rows [GRID_SIZE];
    logic [63:0] tail_row;
    logic [63:0] rule_row;
    logic [63:0] above_row;
    logic [63:0] below_row;
    logic        shift_en;
    logic        last_row;
    logic        row_hit;

    assign shift_en = (state_reg == ST_SWEEP);

    for (genvar i = 0; i < GRID_SIZE; i++)
    begin : g_ring
        lgs_row_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .row_in   ((i == GRID_SIZE - 1) ? tail_row : rows[(i + 1) % GRID_SIZE]),
            .row_out  (rows[i])
        );
    end

    assign last_row  = (cnt_reg == ROW_W'(GRID_SIZE - 1));
    assign above_row = (cnt_reg == '0) ? '0 : above_reg;
    assign below_row = last_row ? '0 : rows[1];
    assign row_hit   = ({1'b0, req_reg.row_index} < 7'(GRID_SIZE))
                       && (req_reg.row_index[ROW_W-1:0] == cnt_reg);

    lgs_rule_unit u_rule (
        .above    (above_row),
        .current  (rows[0]),
        .below    (below_row),
        .next_row (rule_row)
    );

    always_comb
    begin
        case (req_reg.command)
            CMD_WRITE:   tail_row = row_hit ? (req_reg.row_bits & COL_MASK) : rows[0];
            CMD_ADVANCE: tail_row = rule_row;
            default:     tail_row = rows[0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        above_next = above_reg;
        data_next  = data_reg;
        live_next  = live_reg;
        done_next  = 1'b0;
        resp_next  = resp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    cnt_next   = '0;
                    data_next  = '0;
                    live_next  = 1'b0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                above_next = rows[0];
                if ((req_reg.command == CMD_READ) && row_hit)
                begin
                    data_next = rows[0];
                end
                live_next = live_reg | (tail_row != '0);
                cnt_next  = cnt_reg + 1'b1;
                if (last_row)
                begin
                    done_next            = 1'b1;
                    resp_next.row_data   = data_next;
                    resp_next.world_empty = !live_next;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        above_reg <= above_next;
        data_reg  <= data_next;
        resp_reg  <= resp_next;
    end

    assign busy     = (state_reg == ST_SWEEP);
    assign done     = done_reg;
    assign response = resp_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step testbench
// Drives row writes, row reads, generation steps and unused commands into the
// engine and checks every response against a cycle-free model of the B3/S23 grid.
// ----------------------------------------------------------------------------
module tb_top;

    import lgs_pkg::*;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CLK_HALF    = 4;
    localparam int          ITEM_TARGET = 1950;
    localparam int unsigned STALL_LIMIT = 20 * (GRID_SIZE + 1 + 8);

    typedef struct {
        lgs_request_t req;
        int unsigned  gap;
        bit           drain;
    } pending_item_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    lgs_request_t  request = '0;
    logic          done;
    lgs_response_t response;

    pending_item_t stim_q[$];
    lgs_response_t expected_q[$];
    logic [63:0]   life_grid [GRID_SIZE];
    lgs_response_t due_response;

    int unsigned issued_cnt = 0;
    int unsigned accept_cnt = 0;
    int unsigned gap_left = 0;
    bit          gap_armed = 1'b0;
    bit          quiet_stretch = 1'b0;
    int unsigned queued_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_write = 0;
    int unsigned n_read = 0;
    int unsigned n_advance = 0;
    int unsigned n_unused = 0;
    int unsigned n_empty = 0;
    int unsigned n_results = 0;

    life_generation_step_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic logic [63:0] next_cells(input logic [63:0] above,
                                               input logic [63:0] cur,
                                               input logic [63:0] below);
        logic [63:0] born;
        int          count;
        born = '0;
        for (int j = 0; j < 64; j++)
        begin
            count = 0;
            for (int dj = -1; dj <= 1; dj++)
            begin
                if (j + dj >= 0 && j + dj < 64)
                begin
                    count += above[j + dj] + below[j + dj];
                    if (dj != 0)
                        count += cur[j + dj];
                end
            end
            born[j] = (count == BIRTH_COUNT) || (cur[j] && count == SURVIVE_COUNT);
        end
        return born & COL_MASK;
    endfunction

    function automatic lgs_response_t step_grid(input lgs_request_t req);
        lgs_response_t rsp;
        logic [63:0]   prior [GRID_SIZE];
        logic [63:0]   above;
        logic [63:0]   below;
        rsp = '0;
        case (req.command)
            CMD_WRITE:
                if (req.row_index < GRID_SIZE)
                    life_grid[req.row_index] = req.row_bits & COL_MASK;
            CMD_READ:
                if (req.row_index < GRID_SIZE)
                    rsp.row_data = life_grid[req.row_index];
            CMD_ADVANCE:
            begin
                prior = life_grid;
                for (int r = 0; r < GRID_SIZE; r++)
                begin
                    above = (r > 0) ? prior[r - 1] : '0;
                    below = (r + 1 < GRID_SIZE) ? prior[r + 1] : '0;
                    life_grid[r] = next_cells(above, prior[r], below);
                end
            end
            default:
            begin
            end
        endcase
        rsp.world_empty = 1'b1;
        for (int r = 0; r < GRID_SIZE; r++)
            if (life_grid[r] != '0)
                rsp.world_empty = 1'b0;
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_item(input logic [1:0] cmd, input int row,
                            input logic [63:0] bits, input bit drain = 1'b0);
        pending_item_t item;
        item.req.command   = cmd;
        item.req.row_index = row[5:0];
        item.req.row_bits  = bits;
        item.gap           = quiet_stretch ? 0 : $urandom_range(0, 8);
        item.drain         = drain;
        stim_q.push_back(item);
        queued_cnt++;
    endtask

    function automatic logic [63:0] draw_cells();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return a & {$urandom, $urandom} & {$urandom, $urandom};
            1: return '1;
            2: return '0;
            3: return 64'd1 << $urandom_range(0, 63);
            default: return a;
        endcase
    endfunction

    task automatic add_pattern(input int row, input int col);
        case ($urandom_range(0, 2))
            0:
            begin
                add_item(CMD_WRITE, row,     64'd2 << col);
                add_item(CMD_WRITE, row + 1, 64'd4 << col);
                add_item(CMD_WRITE, row + 2, 64'd7 << col);
            end
            1:
                add_item(CMD_WRITE, row + 1, 64'd7 << col);
            default:
            begin
                add_item(CMD_WRITE, row,     64'd3 << col);
                add_item(CMD_WRITE, row + 1, 64'd3 << col);
            end
        endcase
    endtask

    task automatic build_stimulus();
        int          sel;
        int          steps;
        logic [1:0]  cmd;
        int unsigned pick;
        // Directed part: full rows on both borders, the unused command,
        // an empty world and blinkers against the first and last columns.
        add_item(CMD_READ, 0, '1);
        add_item(CMD_WRITE, 0, '1);
        add_item(CMD_READ, 0, '0);
        add_item(CMD_WRITE, 63, '1);
        add_item(CMD_READ, 63, '1);
        add_item(CMD_UNUSED, 5, {$urandom, $urandom});
        add_item(CMD_ADVANCE, 0, '1);
        add_item(CMD_READ, 0, '0);
        add_item(CMD_READ, 1, '0);
        add_item(CMD_WRITE, 0, '0);
        add_item(CMD_WRITE, 1, '0);
        add_item(CMD_WRITE, 62, '0);
        add_item(CMD_WRITE, 63, '0);
        add_item(CMD_ADVANCE, 17, '0, 1'b1);
        add_item(CMD_WRITE, 40, 64'd7 << 61);
        add_item(CMD_WRITE, 31, 64'd7);
        add_item(CMD_ADVANCE, 0, '0);
        add_item(CMD_READ, 39, '0);
        add_item(CMD_READ, 40, '0);
        add_item(CMD_READ, 41, '0);
        add_item(CMD_READ, 32, '0);
        add_item(CMD_ADVANCE, 0, '0);
        add_item(CMD_READ, 40, '0);
        add_item(CMD_UNUSED, 63, '1);

        while (queued_cnt < ITEM_TARGET)
        begin
            quiet_stretch = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 14);
            if (sel == 0)
            begin
                for (int r = 0; r < GRID_SIZE; r++)
                    add_item(CMD_WRITE, r, '0);
            end
            else if (sel <= 7)
            begin
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    add_pattern($urandom_range(0, 61), $urandom_range(0, 61));
                steps = $urandom_range(1, 12);
                for (int s = 0; s < steps; s++)
                begin
                    add_item(CMD_ADVANCE, $urandom_range(0, 63), {$urandom, $urandom},
                             $urandom_range(0, 40) == 0);
                    for (int k = $urandom_range(0, 2); k > 0; k--)
                        add_item(CMD_READ, $urandom_range(0, 63), {$urandom, $urandom});
                end
            end
            else
            begin
                for (int k = $urandom_range(5, 20); k > 0; k--)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 8)
                        cmd = CMD_WRITE;
                    else if (pick < 15)
                        cmd = CMD_READ;
                    else if (pick < 19)
                        cmd = CMD_ADVANCE;
                    else
                        cmd = CMD_UNUSED;
                    add_item(cmd, $urandom_range(0, 63), draw_cells(),
                             $urandom_range(0, 50) == 0);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && issued_cnt == accept_cnt)
        begin
            if (stim_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                if (!gap_armed)
                begin
                    gap_left  = stim_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (stim_q[0].drain && expected_q.size() != 0)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    request <= stim_q[0].req;
                    start   <= 1'b1;
                    stim_q.pop_front();
                    gap_armed = 1'b0;
                    issued_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("response with no transaction pending",
                                    response.row_data, '0);
                end
                else
                begin
                    due_response = expected_q.pop_front();
                    n_results++;
                    if (due_response.world_empty)
                        n_empty++;
                    if (response.row_data !== due_response.row_data)
                        report_mismatch("row_data", response.row_data,
                                        due_response.row_data);
                    if (response.world_empty !== due_response.world_empty)
                        report_mismatch("world_empty", 64'(response.world_empty),
                                        64'(due_response.world_empty));
                end
            end
            if (start && !busy)
            begin
                expected_q.push_back(step_grid(request));
                accept_cnt++;
                case (request.command)
                    CMD_WRITE:   n_write++;
                    CMD_READ:    n_read++;
                    CMD_ADVANCE: n_advance++;
                    default:     n_unused++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] Timeout: no transaction for %0d cycles, %0d results due",
                         $time, idle_cycles, expected_q.size());
                $display("FAIL life_generation_step_top");
                $finish;
            end
        end
    end

    initial
    begin
        for (int r = 0; r < GRID_SIZE; r++)
            life_grid[r] = '0;
        build_stimulus();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (stim_q.size() == 0 && issued_cnt == accept_cnt && expected_q.size() == 0);
        repeat (GRID_SIZE + 16) @(posedge clk);
        $display("Covered %0d transactions: %0d row writes, %0d row reads, %0d generations,",
                 accept_cnt, n_write, n_read, n_advance);
        $display("%0d unused commands; %0d of %0d responses reported an empty grid.",
                 n_unused, n_empty, n_results);
        if (mismatches == 0)
            $display("PASS life_generation_step_top");
        else
            $display("FAIL life_generation_step_top");
        $finish;
    end

endmodule
